### hdl/sfcs_pkg.sv
// Shared types and constants of the SPI flash command sequencer.
// Used by the front end, the queue, the back end and the checker.
// No dependencies.
package sfcs_pkg;

   // Request codes on the input tuser.
   localparam logic [3:0] ACT_READ      = 4'd0;
   localparam logic [3:0] ACT_WRITE     = 4'd1;
   localparam logic [3:0] ACT_SECTOR    = 4'd2;
   localparam logic [3:0] ACT_BULK      = 4'd3;
   localparam logic [3:0] ACT_STATUS    = 4'd4;
   localparam logic [3:0] ACT_SIGNATURE = 4'd5;
   localparam logic [3:0] ACT_POWERDOWN = 4'd6;
   localparam logic [3:0] ACT_WAKEUP    = 4'd7;
   localparam logic [3:0] ACT_WBYTE     = 4'd8;
   localparam logic [3:0] ACT_RESPONSE  = 4'd9;

   // Result kinds on the output tuser.
   localparam logic [2:0] KIND_SEND   = 3'd0;
   localparam logic [2:0] KIND_XCHG   = 3'd1;
   localparam logic [2:0] KIND_DATA   = 3'd2;
   localparam logic [2:0] KIND_STATUS = 3'd3;
   localparam logic [2:0] KIND_SIG    = 3'd4;
   localparam logic [2:0] KIND_DONE   = 3'd5;

   // Flash opcodes.
   localparam logic [7:0] CMD_WREN = 8'h06;
   localparam logic [7:0] CMD_RDSR = 8'h05;
   localparam logic [7:0] CMD_READ = 8'h03;
   localparam logic [7:0] CMD_PP   = 8'h02;
   localparam logic [7:0] CMD_SE   = 8'hd8;
   localparam logic [7:0] CMD_BE   = 8'hc7;
   localparam logic [7:0] CMD_DP   = 8'hb9;
   localparam logic [7:0] CMD_RES  = 8'hab;
   localparam int unsigned BUSY_BIT = 0;
   localparam logic [7:0] XCHG_FILL = 8'hff;

   localparam int unsigned MAX_RESULTS = 8;
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
      logic       release_sel;
   } result_type;

   // One queue entry: every result caused by one accepted item.
   typedef struct packed {
      logic [3:0]                   count;
      result_type [MAX_RESULTS-1:0] items;
   } batch_type;

   function automatic result_type make_result(logic [2:0] kind, logic [7:0] value,
                                               logic release_sel);
      result_type r;
      r.kind = kind;
      r.value = value;
      r.release_sel = release_sel;
      return r;
   endfunction

endpackage

### hdl/sfcs_front.sv
// Front end of the sequencer: takes each request, write byte or response,
// updates the sequencing state and builds the batch of results it causes.
// Depends on sfcs_pkg.
module sfcs_front #(
   parameter int unsigned PAGE_BYTES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [3:0]         action,
   input  logic [23:0]        address,
   input  logic [15:0]        length,
   input  logic [7:0]         sector,
   input  logic [7:0]         data_byte,
   output logic               push,
   output sfcs_pkg::batch_type batch,
   input  logic               queue_full
);

   // The page size must be a power of two; page ends come from the low bits.
   localparam int unsigned PAGE_BITS = $clog2(PAGE_BYTES);

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_POLL   = 3'd1;
   localparam logic [2:0] PH_READ   = 3'd2;
   localparam logic [2:0] PH_WDATA  = 3'd3;
   localparam logic [2:0] PH_STATUS = 3'd4;
   localparam logic [2:0] PH_SIG    = 3'd5;

   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_SECTOR = 2'd2;
   localparam logic [1:0] OP_BULK   = 2'd3;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  op_ff, op_in;
   logic [23:0] addr_ff, addr_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  sector_ff, sector_in;
   logic        then_cmd_ff, then_cmd_in;

   sfcs_pkg::result_type [sfcs_pkg::MAX_RESULTS-1:0] list;
   logic [3:0]  n;
   logic [23:0] addr_inc;
   logic [15:0] left_dec;
   logic        page_end;

   assign in_ready = !queue_full;
   assign addr_inc = addr_ff + 24'd1;
   assign left_dec = left_ff - 16'd1;
   assign page_end = (addr_inc[PAGE_BITS-1:0] == '0);

   always_comb begin
      phase_in    = phase_ff;
      op_in       = op_ff;
      addr_in     = addr_ff;
      left_in     = left_ff;
      sector_in   = sector_ff;
      then_cmd_in = then_cmd_ff;
      list        = '0;
      n           = 4'd0;
      if (action[3] == 1'b0) begin
         if (phase_ff == PH_IDLE) begin
            case (action)
               sfcs_pkg::ACT_READ, sfcs_pkg::ACT_WRITE: begin
                  op_in   = (action == sfcs_pkg::ACT_READ) ? OP_READ : OP_WRITE;
                  addr_in = address;
                  left_in = length;
                  if (action == sfcs_pkg::ACT_WRITE && length == 16'd0) begin
                     list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_DONE, 8'd0, 1'b0);
                     n = n + 4'd1;
                  end else begin
                     list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                          sfcs_pkg::CMD_RDSR, 1'b0);
                     n = n + 4'd1;
                     list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_XCHG,
                                                          sfcs_pkg::XCHG_FILL, 1'b1);
                     n = n + 4'd1;
                     then_cmd_in = 1'b1;
                     phase_in = PH_POLL;
                  end
               end
               sfcs_pkg::ACT_SECTOR, sfcs_pkg::ACT_BULK: begin
                  if (action == sfcs_pkg::ACT_SECTOR) begin
                     op_in = OP_SECTOR;
                     sector_in = sector;
                  end else begin
                     op_in = OP_BULK;
                  end
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                       sfcs_pkg::CMD_RDSR, 1'b0);
                  n = n + 4'd1;
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_XCHG,
                                                       sfcs_pkg::XCHG_FILL, 1'b1);
                  n = n + 4'd1;
                  then_cmd_in = 1'b1;
                  phase_in = PH_POLL;
               end
               sfcs_pkg::ACT_STATUS: begin
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                       sfcs_pkg::CMD_RDSR, 1'b0);
                  n = n + 4'd1;
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_XCHG,
                                                       sfcs_pkg::XCHG_FILL, 1'b1);
                  n = n + 4'd1;
                  phase_in = PH_STATUS;
               end
               sfcs_pkg::ACT_SIGNATURE: begin
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                       sfcs_pkg::CMD_RES, 1'b0);
                  n = n + 4'd1;
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND, 8'd0, 1'b0);
                  n = n + 4'd1;
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND, 8'd0, 1'b0);
                  n = n + 4'd1;
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND, 8'd0, 1'b0);
                  n = n + 4'd1;
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_XCHG,
                                                       sfcs_pkg::XCHG_FILL, 1'b1);
                  n = n + 4'd1;
                  phase_in = PH_SIG;
               end
               default: begin
                  // Power down and wakeup are single-byte frames.
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                     (action == sfcs_pkg::ACT_POWERDOWN) ? sfcs_pkg::CMD_DP
                                                         : sfcs_pkg::CMD_RES, 1'b1);
                  n = n + 4'd1;
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_DONE, 8'd0, 1'b0);
                  n = n + 4'd1;
               end
            endcase
         end
      end else if (action == sfcs_pkg::ACT_WBYTE) begin
         if (phase_ff == PH_WDATA) begin
            addr_in = addr_inc;
            left_in = left_dec;
            list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND, data_byte,
                                                 (left_dec == 16'd0) || page_end);
            n = n + 4'd1;
            if (left_dec == 16'd0) begin
               list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_DONE, 8'd0, 1'b0);
               n = n + 4'd1;
               phase_in = PH_IDLE;
            end else if (page_end) begin
               list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                    sfcs_pkg::CMD_RDSR, 1'b0);
               n = n + 4'd1;
               list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_XCHG,
                                                    sfcs_pkg::XCHG_FILL, 1'b1);
               n = n + 4'd1;
               then_cmd_in = 1'b1;
               phase_in = PH_POLL;
            end
         end
      end else if (action == sfcs_pkg::ACT_RESPONSE) begin
         case (phase_ff)
            PH_POLL: begin
               if (data_byte[sfcs_pkg::BUSY_BIT]) begin
                  // Still busy: another whole read-status frame.
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                       sfcs_pkg::CMD_RDSR, 1'b0);
                  n = n + 4'd1;
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_XCHG,
                                                       sfcs_pkg::XCHG_FILL, 1'b1);
                  n = n + 4'd1;
               end else if (!then_cmd_ff) begin
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_DONE, 8'd0, 1'b0);
                  n = n + 4'd1;
                  phase_in = PH_IDLE;
               end else begin
                  case (op_ff)
                     OP_READ: begin
                        list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                             sfcs_pkg::CMD_READ, 1'b0);
                        n = n + 4'd1;
                        list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                             addr_ff[23:16], 1'b0);
                        n = n + 4'd1;
                        list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                             addr_ff[15:8], 1'b0);
                        n = n + 4'd1;
                        list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                             addr_ff[7:0], left_ff == 16'd0);
                        n = n + 4'd1;
                        if (left_ff == 16'd0) begin
                           list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_DONE,
                                                                8'd0, 1'b0);
                           n = n + 4'd1;
                           phase_in = PH_IDLE;
                        end else begin
                           list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_XCHG,
                              sfcs_pkg::XCHG_FILL, left_ff == 16'd1);
                           n = n + 4'd1;
                           phase_in = PH_READ;
                        end
                     end
                     OP_WRITE: begin
                        list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                             sfcs_pkg::CMD_WREN, 1'b1);
                        n = n + 4'd1;
                        list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                             sfcs_pkg::CMD_PP, 1'b0);
                        n = n + 4'd1;
                        list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                             addr_ff[23:16], 1'b0);
                        n = n + 4'd1;
                        list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                             addr_ff[15:8], 1'b0);
                        n = n + 4'd1;
                        list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                             addr_ff[7:0], 1'b0);
                        n = n + 4'd1;
                        phase_in = PH_WDATA;
                     end
                     default: begin
                        list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                             sfcs_pkg::CMD_WREN, 1'b1);
                        n = n + 4'd1;
                        if (op_ff == OP_SECTOR) begin
                           list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                                sfcs_pkg::CMD_SE, 1'b0);
                           n = n + 4'd1;
                           list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                                sector_ff, 1'b0);
                           n = n + 4'd1;
                           list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                                8'd0, 1'b0);
                           n = n + 4'd1;
                           list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                                8'd0, 1'b1);
                           n = n + 4'd1;
                        end else begin
                           list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                                sfcs_pkg::CMD_BE, 1'b1);
                           n = n + 4'd1;
                        end
                        // The erase is followed by a poll that ends in done.
                        list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SEND,
                                                             sfcs_pkg::CMD_RDSR, 1'b0);
                        n = n + 4'd1;
                        list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_XCHG,
                                                             sfcs_pkg::XCHG_FILL, 1'b1);
                        n = n + 4'd1;
                        then_cmd_in = 1'b0;
                     end
                  endcase
               end
            end
            PH_READ: begin
               list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_DATA, data_byte, 1'b0);
               n = n + 4'd1;
               addr_in = addr_inc;
               left_in = left_dec;
               if (left_dec == 16'd0) begin
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_DONE, 8'd0, 1'b0);
                  n = n + 4'd1;
                  phase_in = PH_IDLE;
               end else begin
                  list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_XCHG,
                                                       sfcs_pkg::XCHG_FILL, left_dec == 16'd1);
                  n = n + 4'd1;
               end
            end
            PH_STATUS: begin
               list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_STATUS, data_byte, 1'b0);
               n = n + 4'd1;
               phase_in = PH_IDLE;
            end
            PH_SIG: begin
               list[n[2:0]] = sfcs_pkg::make_result(sfcs_pkg::KIND_SIG, data_byte, 1'b0);
               n = n + 4'd1;
               phase_in = PH_IDLE;
            end
            default: begin
            end
         endcase
      end
   end

   assign batch.count = n;
   assign batch.items = list;
   assign push = in_valid && in_ready && (n != 4'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         op_ff       <= OP_READ;
         addr_ff     <= '0;
         left_ff     <= '0;
         sector_ff   <= '0;
         then_cmd_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         phase_ff    <= phase_in;
         op_ff       <= op_in;
         addr_ff     <= addr_in;
         left_ff     <= left_in;
         sector_ff   <= sector_in;
         then_cmd_ff <= then_cmd_in;
      end
   end

endmodule

### hdl/sfcs_queue.sv
// Short queue of result batches between the front and back ends.
// Depends on sfcs_pkg.
module sfcs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sfcs_pkg::batch_type push_batch,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output sfcs_pkg::batch_type head
);

   localparam int unsigned PTR_BITS = $clog2(sfcs_pkg::QUEUE_DEPTH);

   sfcs_pkg::batch_type entry_ff [sfcs_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]   fill_ff, fill_in;

   assign full       = (fill_ff == PTR_BITS'(0) + (PTR_BITS+1)'(sfcs_pkg::QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !(pop && head_valid)) begin
         fill_in = fill_ff + (PTR_BITS+1)'(1);
      end else if (!push && pop && head_valid) begin
         fill_in = fill_ff - (PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_batch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop && head_valid) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         end
         fill_ff <= fill_in;
      end
   end

endmodule

### hdl/sfcs_back.sv
// Back end of the sequencer: walks the batch at the head of the queue and
// hands its results to the output channel one transfer at a time.
// Depends on sfcs_pkg.
module sfcs_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  sfcs_pkg::batch_type head,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output sfcs_pkg::result_type out_result,
   output logic                out_last
);

   logic [2:0] idx_ff;

   assign out_valid  = head_valid;
   assign out_result = head.items[idx_ff];
   assign out_last   = ({1'b0, idx_ff} == head.count - 4'd1);
   assign pop        = out_valid && out_ready && out_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (out_valid && out_ready) begin
         idx_ff <= out_last ? 3'd0 : idx_ff + 3'd1;
      end
   end

endmodule

### hdl/spi_flash_command_sequencer.sv
// SPI NOR flash command sequencer, host side: turns flash requests, write
// bytes and returned bytes into SPI byte results with chip-select marks.
// Each accepted item is classified by the front end, which puts
// all of its results (up to seven) into a four-entry queue as one batch; the
// back end then presents them one per cycle on the result channel while
// rsp_tready is high. An item therefore takes one transfer per result, one
// to seven, and an item that causes none puts nothing into the queue. The
// input side keeps taking items while the queue has room, so it stalls only
// when four batches are waiting. PAGE_BYTES must be a power of two.
module spi_flash_command_sequencer #(
   parameter int unsigned PAGE_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // address[23:0], length[39:24], sector[47:40],
                                    // data_byte[55:48]
   input  logic [3:0]  req_tuser,   // action[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // byte_value[7:0], release_select[8], zero[15:9]
   output logic [2:0]  rsp_tuser,   // kind[2:0]
   output logic        rsp_tlast
);

   logic                 push, queue_full, pop, head_valid;
   sfcs_pkg::batch_type  batch, head;
   sfcs_pkg::result_type out_result;

   sfcs_front #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .action     (req_tuser),
      .address    (req_tdata[23:0]),
      .length     (req_tdata[39:24]),
      .sector     (req_tdata[47:40]),
      .data_byte  (req_tdata[55:48]),
      .push       (push),
      .batch      (batch),
      .queue_full (queue_full)
   );

   sfcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_batch (batch),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   sfcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, out_result.release_sel, out_result.value};
   assign rsp_tuser = out_result.kind;

endmodule

### hdl/sfcs_checker.sv
// Port-level checks on the SPI flash command sequencer, bound to its top.
// Depends on sfcs_pkg and spi_flash_command_sequencer.
module sfcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled result holds until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Nothing is left over from before a reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // Done always closes the results of its item.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == sfcs_pkg::KIND_DONE |-> rsp_tlast && rsp_tdata == 16'd0)
      else $error("done result not final or not zero");

   // Returned values never release chip select.
   a_value_no_release: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == sfcs_pkg::KIND_DATA || rsp_tuser == sfcs_pkg::KIND_STATUS
                     || rsp_tuser == sfcs_pkg::KIND_SIG) |-> !rsp_tdata[8])
      else $error("returned value marks a chip-select release");

   // An exchange clocks out the fill byte.
   a_xchg_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == sfcs_pkg::KIND_XCHG
      |-> rsp_tdata[7:0] == sfcs_pkg::XCHG_FILL)
      else $error("exchange without fill byte");

endmodule

bind spi_flash_command_sequencer sfcs_checker u_sfcs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
